[design/pls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Request kinds and status codes shared by the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    // request kind carried on req_type
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2
    } req_kind_t;

    // status code returned with every result
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // fixed field widths of the request and result ports
    localparam int REQ_W   = 2;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

endpackage

[design/positional_list_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of data words addressed by 1-based position, with
// insert, delete and read requests. Every entry register shifts or holds in
// parallel, so one request is handled per cycle.
// ----------------------------------------------------------------------------
//  channel   | signals                             | transfer when
//  ----------+-------------------------------------+----------------------------
//  request   | start, busy, req_type, position,    | start high and busy low
//            | value_in                            |
//  result    | done, status, value_out, count      | every cycle done is high
//
//  A request is registered at the edge that takes it in and its result is
//  registered in the next cycle, in the result register that drives done,
//  status, value_out and count.
//  busy is always low; a new request may follow in every cycle.
//  The entry registers shift in parallel under compare against the position,
//  so the whole list updates at once.
//  Reset clears the length and the valid flags; entry contents are not reset.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_list_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pls_pkg::REQ_W-1:0]          req_type,
    input  logic [pls_pkg::POS_W-1:0]          position,
    input  logic [pls_pkg::DATA_W-1:0]         value_in,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [pls_pkg::DATA_W-1:0]         value_out,
    output logic [pls_pkg::COUNT_W-1:0]        count
);

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((LEN_W > pls_pkg::POS_W) ? LEN_W : pls_pkg::POS_W) + 1;

    // input register
    logic                        in_valid_reg;
    pls_pkg::req_kind_t          kind_reg;
    logic [pls_pkg::POS_W-1:0]   pos_reg;
    logic [VALUE_WIDTH-1:0]      word_reg;

    // list state
    logic [VALUE_WIDTH-1:0]      entries_reg  [DEPTH];
    logic [VALUE_WIDTH-1:0]      entries_next [DEPTH];
    logic [LEN_W-1:0]            length_reg;
    logic [LEN_W-1:0]            length_next;

    // result register
    logic                        done_reg;
    pls_pkg::status_t            status_reg;
    pls_pkg::status_t            status_next;
    logic [pls_pkg::DATA_W-1:0]  rdata_reg;
    logic [pls_pkg::DATA_W-1:0]  rdata_next;
    logic [pls_pkg::COUNT_W-1:0] count_reg;

    // decode helpers
    logic [CMP_W-1:0]            length_ext;
    logic [CMP_W-1:0]            pos_ext;
    logic [CMP_W-1:0]            pos_m1;
    logic [IDX_W-1:0]            pos_idx;
    logic                        ins_ok;
    logic                        del_ok;

    assign busy = 1'b0;

    // request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg <= pls_pkg::req_kind_t'(req_type);
            pos_reg  <= position;
            word_reg <= VALUE_WIDTH'(value_in);
        end
    end

    // range checks against the current length
    assign length_ext = CMP_W'(length_reg);
    assign pos_ext    = CMP_W'(pos_reg);
    assign pos_m1     = pos_ext - CMP_W'(1);
    assign pos_idx    = IDX_W'(pos_m1);

    // request decode
    always_comb
    begin
        status_next = pls_pkg::ST_BADPOS;
        rdata_next  = '0;
        length_next = length_reg;
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        if (in_valid_reg)
        begin
            unique case (kind_reg) inside
                pls_pkg::REQ_INSERT:
                begin
                    if (length_ext >= CMP_W'(DEPTH))
                    begin
                        status_next = pls_pkg::ST_FULL;
                    end
                    else if (pos_ext == '0 || pos_ext > length_ext + CMP_W'(1))
                    begin
                        status_next = pls_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        status_next = pls_pkg::ST_OK;
                        ins_ok      = 1'b1;
                        length_next = length_reg + LEN_W'(1);
                    end
                end
                pls_pkg::REQ_DELETE, pls_pkg::REQ_READ:
                begin
                    if (length_reg == '0)
                    begin
                        status_next = pls_pkg::ST_EMPTY;
                    end
                    else if (pos_ext == '0 || pos_ext > length_ext)
                    begin
                        status_next = pls_pkg::ST_BADPOS;
                    end
                    else if (kind_reg == pls_pkg::REQ_DELETE)
                    begin
                        status_next = pls_pkg::ST_OK;
                        del_ok      = 1'b1;
                        length_next = length_reg - LEN_W'(1);
                    end
                    else
                    begin
                        status_next = pls_pkg::ST_OK;
                        rdata_next  = pls_pkg::DATA_W'(entries_reg[pos_idx]);
                    end
                end
                default:
                begin
                    status_next = pls_pkg::ST_BADPOS;
                end
            endcase
        end
    end

    // per-slot shift: up on insert, down on delete, hold otherwise
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        logic [VALUE_WIDTH-1:0] below;
        logic [VALUE_WIDTH-1:0] above;

        if (i > 0)
        begin : g_below
            assign below = entries_reg[i-1];
        end
        else
        begin : g_below_none
            assign below = entries_reg[i];
        end

        if (i < DEPTH - 1)
        begin : g_above
            assign above = entries_reg[i+1];
        end
        else
        begin : g_above_none
            assign above = entries_reg[i];
        end

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (ins_ok)
            begin
                if (CMP_W'(i) == pos_m1)
                begin
                    entries_next[i] = word_reg;
                end
                else if (CMP_W'(i) > pos_m1)
                begin
                    entries_next[i] = below;
                end
            end
            else if (del_ok && CMP_W'(i) >= pos_m1)
            begin
                entries_next[i] = above;
            end
        end

        always_ff @(posedge clk)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    // length and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            done_reg   <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            count_reg  <= pls_pkg::COUNT_W'(length_next);
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = rdata_reg;
    assign count     = count_reg;

endmodule
